FILE: rtl/fsfla_pkg.sv
// ----------------------------------------------------------------------------
// fsfla_pkg
// Shared constants and types for the free-list slot allocator.
// ----------------------------------------------------------------------------
package fsfla_pkg;

	localparam int MAX_BLOCKS    = 16;
	localparam int MAX_BLK_SLOTS = 64;
	localparam int SLOT_COUNT    = MAX_BLOCKS * MAX_BLK_SLOTS;

	localparam int BLK_W     = $clog2(MAX_BLOCKS);
	localparam int POS_W     = $clog2(MAX_BLK_SLOTS);
	localparam int SLOT_W    = BLK_W + POS_W;
	localparam int LINK_W    = SLOT_W + 1;
	localparam int OBJ_CNT_W = 7;
	localparam int BLK_CNT_W = 5;
	localparam int LIVE_W    = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 7;

	localparam logic [LINK_W-1:0]    NULL_LINK = LINK_W'(SLOT_COUNT);
	localparam logic [LIVE_W-1:0]    LIVE_MAX  = '1;
	localparam logic [OBJ_CNT_W-1:0] OBJS_MIN  = OBJ_CNT_W'(2);
	localparam logic [OBJ_CNT_W-1:0] OBJS_MAX  = OBJ_CNT_W'(MAX_BLK_SLOTS);
	localparam logic [BLK_CNT_W-1:0] BLKS_MAX  = BLK_CNT_W'(MAX_BLOCKS);
	localparam logic [OBJ_CNT_W-1:0] OBJS_RST  = OBJ_CNT_W'(32);
	localparam logic [BLK_CNT_W-1:0] LIMIT_RST = BLK_CNT_W'(16);

	typedef enum logic [1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_RESET   = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_ZERO_LIVE = 2'd2,
		ST_NOT_OPEN  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLK_SLOTS   = 1'd0,
		REG_BLOCK_LIMIT = 1'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LINK,
		S_POP_RD,
		S_POP_WB
	} state_t;

endpackage

FILE: rtl/fixed_size_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_size_free_list_allocator
// Slot allocator over a fixed store of blocks with a LIFO free list.
//
// Pulse start with kind and slot while busy is low to issue a command.
// Each command returns one result on granted_slot, status, live_count and
// blocks_used, marked by a one-cycle done strobe; the receiver cannot
// stall, so it must take the transfer in that cycle.
// Steps from the accepting edge to the done strobe:
//   release or unknown kind: done in the next cycle
//   allocate, list not empty: link table read, then head update
//   allocate opening a block: one link write per slot of the block,
//     then the pop
//   pool reset: one link write per slot of every open block
// The link writes in these loops go one per cycle.
// busy is high while a command is in progress; the next command can be
// accepted in the done cycle, so each command holds the block until its done strobe.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once.
// Reset leaves the free list empty, no blocks open, live count zero; the
// link table is not cleared and is always written before it is read.
// ----------------------------------------------------------------------------
module fixed_size_free_list_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     kind,
	input  logic [fsfla_pkg::SLOT_W-1:0]   slot,
	output logic                           done,
	output logic [fsfla_pkg::SLOT_W-1:0]   granted_slot,
	output logic [1:0]                     status,
	output logic [fsfla_pkg::LIVE_W-1:0]   live_count,
	output logic [fsfla_pkg::BLK_CNT_W-1:0] blocks_used,
	input  logic                           cfg_we,
	input  logic [fsfla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsfla_pkg::CFG_W-1:0]    cfg_data
);

	import fsfla_pkg::*;

	state_t                 state_q, state_d;
	logic [LINK_W-1:0]      head_q, head_d;
	logic [LIVE_W-1:0]      live_q, live_d;
	logic [BLK_CNT_W-1:0]   open_q, open_d;
	logic [BLK_W-1:0]       blk_q, blk_d;
	logic [POS_W-1:0]       pos_q, pos_d;
	logic                   alloc_mode_q, alloc_mode_d;
	logic                   done_q, done_d;
	logic [SLOT_W-1:0]      granted_q, granted_d;
	status_t                status_q, status_d;
	logic [OBJ_CNT_W-1:0]   objs_q;
	logic [BLK_CNT_W-1:0]   limit_q;

	logic [OBJ_CNT_W-1:0]   eff_objs;
	logic [BLK_CNT_W-1:0]   eff_limit;
	logic [POS_W-1:0]       last_pos;
	logic [SLOT_W-1:0]      link_slot;
	logic [BLK_W-1:0]       rel_blk;
	logic [POS_W-1:0]       rel_pos;
	logic                   accept;

	logic                   mem_we;
	logic [SLOT_W-1:0]      mem_waddr;
	logic [LINK_W-1:0]      mem_wdata;
	logic                   mem_re;
	logic [SLOT_W-1:0]      mem_raddr;
	logic [LINK_W-1:0]      mem_rdata;

	fsfla_ram #(
		.WIDTH (LINK_W),
		.DEPTH (SLOT_COUNT)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// saturate configuration into its working range
	always_comb begin
		if (objs_q < OBJS_MIN) begin
			eff_objs = OBJS_MIN;
		end else if (objs_q > OBJS_MAX) begin
			eff_objs = OBJS_MAX;
		end else begin
			eff_objs = objs_q;
		end
		eff_limit = (limit_q > BLKS_MAX) ? BLKS_MAX : limit_q;
	end

	assign last_pos  = POS_W'(eff_objs - OBJ_CNT_W'(1));
	assign link_slot = {blk_q, pos_q};
	assign rel_blk   = slot[SLOT_W-1:POS_W];
	assign rel_pos   = slot[POS_W-1:0];
	assign accept    = start && (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		live_d       = live_q;
		open_d       = open_q;
		blk_d        = blk_q;
		pos_d        = pos_q;
		alloc_mode_d = alloc_mode_q;
		done_d       = 1'b0;
		granted_d    = '0;
		status_d     = ST_OK;
		mem_we       = 1'b0;
		mem_waddr    = link_slot;
		mem_wdata    = head_q;
		mem_re       = 1'b0;
		mem_raddr    = head_q[SLOT_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (kind_t'(kind))
						KIND_ALLOC: begin
							if (head_q != NULL_LINK) begin
								state_d = S_POP_RD;
							end else if (open_q < eff_limit) begin
								blk_d        = open_q[BLK_W-1:0];
								pos_d        = '0;
								open_d       = open_q + BLK_CNT_W'(1);
								alloc_mode_d = 1'b1;
								state_d      = S_LINK;
							end else begin
								done_d   = 1'b1;
								status_d = ST_EXHAUSTED;
							end
						end
						KIND_RELEASE: begin
							done_d = 1'b1;
							if (({1'b0, rel_blk} >= open_q) ||
							    ({1'b0, rel_pos} >= eff_objs)) begin
								status_d = ST_NOT_OPEN;
							end else if (live_q == '0) begin
								status_d = ST_ZERO_LIVE;
							end else begin
								// push the slot on the free list
								mem_we    = 1'b1;
								mem_waddr = slot;
								head_d    = {1'b0, slot};
								live_d    = live_q - LIVE_W'(1);
							end
						end
						KIND_RESET: begin
							head_d = NULL_LINK;
							live_d = '0;
							if (open_q == '0) begin
								done_d = 1'b1;
							end else begin
								blk_d        = BLK_W'(open_q - BLK_CNT_W'(1));
								pos_d        = '0;
								alloc_mode_d = 1'b0;
								state_d      = S_LINK;
							end
						end
						KIND_NONE: begin
							done_d = 1'b1;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_LINK: begin
				// push one slot per cycle, first to last within a block
				mem_we = 1'b1;
				head_d = {1'b0, link_slot};
				if (pos_q == last_pos) begin
					pos_d = '0;
					if (alloc_mode_q) begin
						state_d = S_POP_RD;
					end else if (blk_q == '0) begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end else begin
						blk_d = blk_q - BLK_W'(1);
					end
				end else begin
					pos_d = pos_q + POS_W'(1);
				end
			end
			S_POP_RD: begin
				mem_re  = 1'b1;
				state_d = S_POP_WB;
			end
			S_POP_WB: begin
				done_d    = 1'b1;
				granted_d = head_q[SLOT_W-1:0];
				head_d    = mem_rdata;
				if (live_q != LIVE_MAX) begin
					live_d = live_q + LIVE_W'(1);
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= NULL_LINK;
			live_q       <= '0;
			open_q       <= '0;
			alloc_mode_q <= 1'b0;
			done_q       <= 1'b0;
			objs_q       <= OBJS_RST;
			limit_q      <= LIMIT_RST;
		end else begin
			state_q      <= state_d;
			head_q       <= head_d;
			live_q       <= live_d;
			open_q       <= open_d;
			alloc_mode_q <= alloc_mode_d;
			done_q       <= done_d;
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_BLK_SLOTS:   objs_q  <= cfg_data;
					REG_BLOCK_LIMIT: limit_q <= cfg_data[BLK_CNT_W-1:0];
					default:         objs_q  <= objs_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		blk_q     <= blk_d;
		pos_q     <= pos_d;
		granted_q <= granted_d;
		status_q  <= status_d;
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign granted_slot = granted_q;
	assign status       = status_q;
	assign live_count   = live_q;
	assign blocks_used  = open_q;

`ifndef SYNTHESIS
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted command neither in progress nor finished");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= BLKS_MAX)
		else $error("open block count beyond store size");

	a_error_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> ($stable(live_count) && $stable(blocks_used)))
		else $error("failed command changed pool counters");

	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (granted_slot != '0)) |-> (status == ST_OK))
		else $error("slot granted with error status");
`endif

endmodule

FILE: rtl/fsfla_ram.sv
// ----------------------------------------------------------------------------
// fsfla_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fsfla_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: dv/tb_fixed_size_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_size_free_list_allocator
// Self-checking bench for the free-list slot allocator. A local model of
// the link table, list head, live count and open blocks predicts every
// result; a monitor compares each done transfer field by field. Directed
// commands cover the corner cases, then randomized traffic runs through a
// series of register settings with bursty command issue.
// ----------------------------------------------------------------------------
module tb_fixed_size_free_list_allocator;
	import fsfla_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0]    granted;
		status_t              status;
		logic [LIVE_W-1:0]    live;
		logic [BLK_CNT_W-1:0] blocks;
	} pool_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic [1:0]            kind      = KIND_ALLOC;
	logic [SLOT_W-1:0]     slot      = '0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_BLK_SLOTS;
	logic [CFG_W-1:0]      cfg_data  = '0;
	logic                  busy;
	logic                  done;
	logic [SLOT_W-1:0]     granted_slot;
	logic [1:0]            status;
	logic [LIVE_W-1:0]     live_count;
	logic [BLK_CNT_W-1:0]  blocks_used;

	// Pool model state
	logic [LINK_W-1:0]     link_tbl [SLOT_COUNT];
	logic [LINK_W-1:0]     head_m    = NULL_LINK;
	int unsigned           live_m    = 0;
	int unsigned           blocks_m  = 0;
	logic [OBJ_CNT_W-1:0]  objs_m    = OBJS_RST;
	logic [BLK_CNT_W-1:0]  limit_m   = LIMIT_RST;
	int unsigned           held_q [$];
	logic [SLOT_W-1:0]     last_freed = '0;

	pool_result_t          pool_result_q [$];
	int unsigned           error_count = 0;
	int unsigned           cmds_sent = 0;
	int unsigned           results_checked = 0;
	int unsigned           cfg_writes = 0;
	int unsigned           status_seen [4] = '{0, 0, 0, 0};
	int unsigned           burst_left = 0;

	fixed_size_free_list_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.slot         (slot),
		.done         (done),
		.granted_slot (granted_slot),
		.status       (status),
		.live_count   (live_count),
		.blocks_used  (blocks_used),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		error_count++;
	endtask

	function automatic int unsigned slots_per_block();
		if (objs_m < OBJS_MIN)
			return OBJS_MIN;
		if (objs_m > OBJS_MAX)
			return OBJS_MAX;
		return objs_m;
	endfunction

	function automatic void push_free(int unsigned s);
		link_tbl[s] = head_m;
		head_m = LINK_W'(s);
	endfunction

	function automatic void link_whole_block(int unsigned b);
		int unsigned n;
		n = slots_per_block();
		for (int unsigned i = 0; i < n; i++)
			push_free(b * MAX_BLK_SLOTS + i);
	endfunction

	function automatic pool_result_t apply_pool_cmd(kind_t k, logic [SLOT_W-1:0] s);
		pool_result_t r;
		int unsigned  b;
		int unsigned  p;
		int unsigned  cap;
		int           j;
		r = '0;
		r.status = ST_OK;
		case (k)
			KIND_ALLOC: begin
				cap = (limit_m > BLKS_MAX) ? BLKS_MAX : limit_m;
				// open a fresh block only when the list has run dry
				if (head_m >= SLOT_COUNT && blocks_m < cap) begin
					link_whole_block(blocks_m);
					blocks_m++;
				end
				if (head_m >= SLOT_COUNT) begin
					r.status = ST_EXHAUSTED;
				end else begin
					r.granted = head_m[SLOT_W-1:0];
					held_q.push_back(head_m);
					head_m = link_tbl[head_m];
					if (live_m < LIVE_MAX)
						live_m++;
				end
			end
			KIND_RELEASE: begin
				b = s / MAX_BLK_SLOTS;
				p = s % MAX_BLK_SLOTS;
				if (b >= blocks_m || p >= slots_per_block()) begin
					r.status = ST_NOT_OPEN;
				end else if (live_m == 0) begin
					r.status = ST_ZERO_LIVE;
				end else begin
					push_free(s);
					live_m--;
					last_freed = s;
					for (j = 0; j < held_q.size(); j++) begin
						if (held_q[j] == s) begin
							held_q.delete(j);
							break;
						end
					end
				end
			end
			KIND_RESET: begin
				head_m = NULL_LINK;
				live_m = 0;
				held_q.delete();
				// newest block first, so the oldest block ends on top
				b = blocks_m;
				while (b > 0) begin
					b--;
					link_whole_block(b);
				end
			end
			default: ;
		endcase
		r.live = live_m[LIVE_W-1:0];
		r.blocks = blocks_m[BLK_CNT_W-1:0];
		return r;
	endfunction

	// Hold start until the transfer, then predict; idle between bursts.
	task automatic issue_cmd(kind_t k, logic [SLOT_W-1:0] s);
		int unsigned gap;
		start <= 1'b1;
		kind  <= k;
		slot  <= s;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pool_result_q.push_back(apply_pool_cmd(k, s));
		cmds_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drain all outstanding commands before touching a register.
	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		start <= 1'b0;
		while (pool_result_q.size() != 0 || busy)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == REG_BLK_SLOTS)
			objs_m = val;
		else
			limit_m = val[BLK_CNT_W-1:0];
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	always @(posedge clk) begin
		pool_result_t exp_r;
		if (arst_n && done) begin
			if (pool_result_q.size() == 0) begin
				report_mismatch("done strobe with no command outstanding");
			end else begin
				exp_r = pool_result_q.pop_front();
				if (granted_slot !== exp_r.granted)
					report_mismatch($sformatf("result %0d granted_slot got %0d want %0d",
						results_checked, granted_slot, exp_r.granted));
				if (status !== exp_r.status)
					report_mismatch($sformatf("result %0d status got %0d want %s",
						results_checked, status, exp_r.status.name()));
				if (live_count !== exp_r.live)
					report_mismatch($sformatf("result %0d live_count got %0d want %0d",
						results_checked, live_count, exp_r.live));
				if (blocks_used !== exp_r.blocks)
					report_mismatch($sformatf("result %0d blocks_used got %0d want %0d",
						results_checked, blocks_used, exp_r.blocks));
				status_seen[exp_r.status]++;
				results_checked++;
			end
		end
	end

	// Pops, pushes, double release, bad slots and pool reset at reset settings.
	task automatic test_directed_ops();
		issue_cmd(KIND_RELEASE, 10'd0);
		issue_cmd(KIND_ALLOC, 10'd1023);
		issue_cmd(KIND_ALLOC, 10'd0);
		issue_cmd(KIND_RELEASE, 10'd31);
		issue_cmd(KIND_RELEASE, 10'd1023);
		issue_cmd(KIND_RELEASE, 10'd32);
		issue_cmd(KIND_NONE, 10'd1023);
		issue_cmd(KIND_RELEASE, 10'd30);
		issue_cmd(KIND_RELEASE, 10'd30);
		issue_cmd(KIND_ALLOC, 10'd0);
		issue_cmd(KIND_ALLOC, 10'd0);
		// push the same slot twice while live is still nonzero
		issue_cmd(KIND_RELEASE, 10'd31);
		issue_cmd(KIND_RELEASE, 10'd31);
		issue_cmd(KIND_ALLOC, 10'd0);
		issue_cmd(KIND_ALLOC, 10'd0);
		issue_cmd(KIND_RESET, 10'd1023);
	endtask

	// Saturated slot count, zero block limit, slot count grown after open.
	task automatic test_config_corners();
		write_reg(REG_BLK_SLOTS, 7'd0);
		write_reg(REG_BLOCK_LIMIT, 7'd0);
		issue_cmd(KIND_RESET, 10'd0);
		issue_cmd(KIND_ALLOC, 10'd0);
		issue_cmd(KIND_ALLOC, 10'd0);
		issue_cmd(KIND_ALLOC, 10'd0);
		issue_cmd(KIND_RELEASE, 10'd5);
		write_reg(REG_BLK_SLOTS, 7'd127);
		write_reg(REG_BLOCK_LIMIT, 7'd31);
		issue_cmd(KIND_RELEASE, 10'd63);
		issue_cmd(KIND_ALLOC, 10'd0);
		issue_cmd(KIND_ALLOC, 10'd0);
		issue_cmd(KIND_RESET, 10'd512);
		issue_cmd(KIND_ALLOC, 10'd0);
	endtask

	// Mostly alloc/release of held slots, with noise, across many settings.
	task automatic test_random_traffic();
		logic [OBJ_CNT_W-1:0] objs_tbl [10];
		logic [BLK_CNT_W-1:0] limit_tbl [10];
		logic [OBJ_CNT_W-1:0] objs;
		logic [BLK_CNT_W-1:0] limit;
		logic [SLOT_W-1:0]    target;
		int unsigned          alloc_pct;
		int unsigned          pick;
		int unsigned          blk;
		kind_t                k;
		objs_tbl  = '{7'd0, 7'd3, 7'd5, 7'd127, 7'd7, 7'd64, 7'd2, 7'd1, 7'd64, 7'd4};
		limit_tbl = '{5'd1, 5'd2, 5'd0, 5'd4, 5'd6, 5'd31, 5'd16, 5'd17, 5'd16, 5'd16};
		for (int ph = 0; ph < 12; ph++) begin
			if (ph < 10) begin
				objs  = objs_tbl[ph];
				limit = limit_tbl[ph];
			end else begin
				objs  = OBJ_CNT_W'($urandom_range(127));
				limit = BLK_CNT_W'($urandom_range(31));
			end
			write_reg(REG_BLK_SLOTS, objs);
			write_reg(REG_BLOCK_LIMIT, {2'($urandom_range(3)), limit});
			if ($urandom_range(1))
				issue_cmd(KIND_RESET, SLOT_W'($urandom_range(1023)));
			alloc_pct = $urandom_range(40, 70);
			repeat (150) begin
				pick   = $urandom_range(99);
				target = SLOT_W'($urandom_range(1023));
				if (pick < 2) begin
					k = KIND_NONE;
				end else if (pick < 4) begin
					k = KIND_RESET;
				end else if (pick < 4 + alloc_pct || (held_q.size() == 0 && pick < 80)) begin
					k = KIND_ALLOC;
				end else begin
					k = KIND_RELEASE;
					pick = $urandom_range(9);
					if (pick < 7 && held_q.size() != 0) begin
						target = SLOT_W'(held_q[$urandom_range(held_q.size() - 1)]);
					end else if (pick < 8) begin
						target = last_freed;
					end else if (pick < 9) begin
						// near the open region, one block past it included
						blk = $urandom_range((blocks_m < 15) ? blocks_m : 15);
						target = {blk[BLK_W-1:0], POS_W'($urandom_range(63))};
					end
				end
				issue_cmd(k, target);
			end
		end
	endtask

	initial begin
		int unsigned wait_cycles;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_config_corners();
		test_random_traffic();
		start <= 1'b0;
		for (wait_cycles = 0; wait_cycles < 4000 && pool_result_q.size() != 0; wait_cycles++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (pool_result_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pool_result_q.size()));
		$display("Ran %0d commands, checked %0d results, %0d register writes, %0d blocks open",
			cmds_sent, results_checked, cfg_writes, blocks_m);
		$display("Status mix: ok %0d, exhausted %0d, zero live %0d, not open %0d",
			status_seen[ST_OK], status_seen[ST_EXHAUSTED], status_seen[ST_ZERO_LIVE],
			status_seen[ST_NOT_OPEN]);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#(100_000_000);
		$display("Timeout: run did not finish, %0d results outstanding", pool_result_q.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
